FILE: sv/ffba_pkg.sv
// Shared codes and types for the first-fit block allocator.
// No dependencies; used by the allocator top and both testbench modules through scoped names.
package ffba_pkg;

    typedef logic [1:0] cmd_t;
    typedef logic [1:0] status_t;
    typedef logic       reg_index_t;

    // Operation codes carried in s_axis_tuser
    localparam cmd_t CMD_ALLOC   = 2'd0;
    localparam cmd_t CMD_FREE    = 2'd1;
    localparam cmd_t CMD_REALLOC = 2'd2;

    // Result status codes
    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_NOT_FOUND = 2'd1;
    localparam status_t STATUS_FULL      = 2'd2;
    localparam status_t STATUS_EXHAUSTED = 2'd3;

    // Configuration register indexes
    localparam reg_index_t REG_HEAP_BASE = 1'b0;
    localparam reg_index_t REG_HEAP_SIZE = 1'b1;

    localparam logic [31:0] HEAP_BASE_RESET = 32'd4096;
    localparam logic [31:0] HEAP_SIZE_RESET = 32'd65536;

    // Carved blocks are rounded up to a multiple of eight; this is the rounding mask
    localparam logic [32:0] CARVE_ROUND = 33'd7;

endpackage

FILE: sv/first_fit_block_allocator.sv
// First-fit block allocator: scan sequencer, heap top and result register.
// Depends on ffba_pkg and ffba_desc_mem.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tuser: cmd; tdata: block_address, request_size
//  m_axis    out  tvalid/tready          tdata: result_address, status
//  config    in   wr_en (always taken)   wr_index, wr_data
//
// Each request scans the descriptors at one a cycle through the single memory read port,
// stopping on a hit or running through the table, then makes at most three write-backs.
// Unused commands skip the scan. Reset empties the table at once, no sweep. A new item
// is taken while a result waits on m_axis; the next result is held in S_DONE until the
// output register frees.
module first_fit_block_allocator #(
    parameter int ENTRIES    = 64,
    parameter int ADDR_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] block_address, [63:32] request_size
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] result_address, [33:32] status, zero pad
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [31:0] wr_data
);

    localparam int IW   = $clog2(ENTRIES);
    localparam int CNTW = $clog2(ENTRIES + 1);
    localparam int AW   = ADDR_WIDTH;
    localparam int CW   = (ADDR_WIDTH > 32) ? ADDR_WIDTH : 32;
    localparam int EW   = ADDR_WIDTH + 33;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_PLAN  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]              state_reg, state_next;
    ffba_pkg::cmd_t          cmd_reg, cmd_next;
    logic [31:0]             addr_reg, addr_next;
    logic [31:0]             size_reg, size_next;
    logic [31:0]             base_reg, base_next;
    logic [31:0]             hsize_reg, hsize_next;
    logic [31:0]             used_reg, used_next;
    logic [CNTW-1:0]         count_reg, count_next;
    logic [CNTW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic                    chk_v_reg, chk_v_next;
    logic [IW-1:0]           chk_idx_reg, chk_idx_next;
    logic                    old_found_reg, old_found_next;
    logic [IW-1:0]           old_idx_reg, old_idx_next;
    logic [AW-1:0]           old_start_reg, old_start_next;
    logic [31:0]             old_len_reg, old_len_next;
    logic                    hit_reg, hit_next;
    logic [IW-1:0]           k_idx_reg, k_idx_next;
    logic [AW-1:0]           k_start_reg, k_start_next;
    logic [31:0]             k_len_reg, k_len_next;
    logic                    wr_old_reg, wr_old_next;
    logic                    wr_k_reg, wr_k_next;
    logic                    wr_app_reg, wr_app_next;
    logic [31:0]             kw_len_reg, kw_len_next;
    logic [AW-1:0]           app_start_reg, app_start_next;
    logic [31:0]             app_len_reg, app_len_next;
    logic                    app_free_reg, app_free_next;
    logic [31:0]             res_addr_reg, res_addr_next;
    ffba_pkg::status_t       res_status_reg, res_status_next;
    logic                    out_valid_reg, out_valid_next;
    logic [31:0]             out_addr_reg, out_addr_next;
    ffba_pkg::status_t       out_status_reg, out_status_next;

    logic                    rd_en;
    logic [EW-1:0]           rd_data;
    logic                    mem_wr_en;
    logic [IW-1:0]           mem_wr_idx;
    logic [EW-1:0]           mem_wr_data;

    logic [AW-1:0]           e_start;
    logic [31:0]             e_len;
    logic                    e_free;
    logic                    e_match;
    logic                    e_fits;
    logic                    e_hit;

    logic [31:0]             rest;
    logic                    room;
    logic [32:0]             rounded;
    logic [33:0]             need;
    logic [32:0]             top_sum;
    logic [AW-1:0]           top;
    logic                    split;

    ffba_desc_mem #(
        .DEPTH (ENTRIES),
        .WIDTH (EW)
    ) u_desc_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_idx  (rd_ptr_reg[IW-1:0]),
        .rd_data (rd_data),
        .wr_en   (mem_wr_en),
        .wr_idx  (mem_wr_idx),
        .wr_data (mem_wr_data)
    );

    // Descriptor layout: {free, length, start}
    assign e_start = rd_data[AW-1:0];
    assign e_len   = rd_data[AW+31:AW];
    assign e_free  = rd_data[EW-1];
    assign e_match = (CW'(e_start) == CW'(addr_reg));
    assign e_fits  = e_free && (e_len >= size_reg);

    always_comb
    begin
        case (cmd_reg)
            ffba_pkg::CMD_ALLOC:   e_hit = e_fits;
            ffba_pkg::CMD_FREE:    e_hit = e_match;
            ffba_pkg::CMD_REALLOC: e_hit = (old_found_reg || e_match) && e_fits;
            default:               e_hit = 1'b0;
        endcase
    end

    assign rd_en = (state_reg == S_SCAN) && (rd_ptr_reg < count_reg);

    assign rest    = k_len_reg - size_reg;
    assign room    = (count_reg < CNTW'(ENTRIES));
    assign rounded = ({1'b0, size_reg} + ffba_pkg::CARVE_ROUND) & ~ffba_pkg::CARVE_ROUND;
    assign need    = {2'b00, used_reg} + {1'b0, rounded};
    assign top_sum = {1'b0, base_reg} + {1'b0, used_reg};
    assign top     = AW'(top_sum);
    assign split   = (rest != 32'd0) && room;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_status_reg, out_addr_reg};

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        size_next       = size_reg;
        base_next       = base_reg;
        hsize_next      = hsize_reg;
        used_next       = used_reg;
        count_next      = count_reg;
        rd_ptr_next     = rd_ptr_reg;
        chk_v_next      = 1'b0;
        chk_idx_next    = rd_ptr_reg[IW-1:0];
        old_found_next  = old_found_reg;
        old_idx_next    = old_idx_reg;
        old_start_next  = old_start_reg;
        old_len_next    = old_len_reg;
        hit_next        = hit_reg;
        k_idx_next      = k_idx_reg;
        k_start_next    = k_start_reg;
        k_len_next      = k_len_reg;
        wr_old_next     = wr_old_reg;
        wr_k_next       = wr_k_reg;
        wr_app_next     = wr_app_reg;
        kw_len_next     = kw_len_reg;
        app_start_next  = app_start_reg;
        app_len_next    = app_len_reg;
        app_free_next   = app_free_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        mem_wr_en       = 1'b0;
        mem_wr_idx      = old_idx_reg;
        mem_wr_data     = {1'b1, old_len_reg, old_start_reg};

        if (wr_en)
        begin
            if (wr_index == ffba_pkg::REG_HEAP_BASE)
            begin
                base_next = wr_data;
            end
            else
            begin
                hsize_next = wr_data;
            end
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next       = s_axis_tuser;
                    addr_next      = s_axis_tdata[31:0];
                    size_next      = s_axis_tdata[63:32];
                    rd_ptr_next    = '0;
                    old_found_next = 1'b0;
                    hit_next       = 1'b0;
                    wr_old_next    = 1'b0;
                    wr_k_next      = 1'b0;
                    wr_app_next    = 1'b0;
                    // unused command skips the scan and answers not found
                    if (s_axis_tuser == ffba_pkg::CMD_ALLOC
                        || s_axis_tuser == ffba_pkg::CMD_FREE
                        || s_axis_tuser == ffba_pkg::CMD_REALLOC)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_PLAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (rd_en)
                begin
                    rd_ptr_next = rd_ptr_reg + CNTW'(1);
                    chk_v_next  = 1'b1;
                end
                if (chk_v_reg)
                begin
                    // record the first descriptor whose start matches
                    if (cmd_reg != ffba_pkg::CMD_ALLOC && !old_found_reg && e_match)
                    begin
                        old_found_next = 1'b1;
                        old_idx_next   = chk_idx_reg;
                        old_start_next = e_start;
                        old_len_next   = e_len;
                    end
                    if (e_hit)
                    begin
                        hit_next     = 1'b1;
                        k_idx_next   = chk_idx_reg;
                        k_start_next = e_start;
                        k_len_next   = e_len;
                        chk_v_next   = 1'b0;
                        state_next   = S_PLAN;
                    end
                end
                else if (rd_ptr_reg >= count_reg)
                begin
                    state_next = S_PLAN;
                end
            end

            S_PLAN:
            begin
                res_addr_next   = 32'd0;
                res_status_next = ffba_pkg::STATUS_NOT_FOUND;
                state_next      = S_WRITE;
                if (cmd_reg == ffba_pkg::CMD_FREE)
                begin
                    if (old_found_reg)
                    begin
                        wr_old_next     = 1'b1;
                        res_status_next = ffba_pkg::STATUS_OK;
                    end
                end
                else if (cmd_reg == ffba_pkg::CMD_ALLOC
                         || (cmd_reg == ffba_pkg::CMD_REALLOC && old_found_reg))
                begin
                    if (hit_reg)
                    begin
                        // shrink the fit and append the remainder when a slot is left
                        wr_k_next       = 1'b1;
                        kw_len_next     = split ? size_reg : k_len_reg;
                        wr_app_next     = split;
                        app_start_next  = k_start_reg + AW'(size_reg);
                        app_len_next    = rest;
                        app_free_next   = 1'b1;
                        wr_old_next     = (cmd_reg == ffba_pkg::CMD_REALLOC)
                                          && (old_idx_reg != k_idx_reg);
                        res_status_next = ffba_pkg::STATUS_OK;
                        res_addr_next   = 32'(k_start_reg);
                    end
                    else if (!room)
                    begin
                        res_status_next = ffba_pkg::STATUS_FULL;
                    end
                    else if (need > {2'b00, hsize_reg})
                    begin
                        res_status_next = ffba_pkg::STATUS_EXHAUSTED;
                    end
                    else
                    begin
                        // carve from the heap top
                        wr_app_next     = 1'b1;
                        app_start_next  = top;
                        app_len_next    = rounded[31:0];
                        app_free_next   = 1'b0;
                        used_next       = used_reg + rounded[31:0];
                        wr_old_next     = (cmd_reg == ffba_pkg::CMD_REALLOC);
                        res_status_next = ffba_pkg::STATUS_OK;
                        res_addr_next   = 32'(top);
                    end
                end
            end

            S_WRITE:
            begin
                if (wr_old_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_idx  = old_idx_reg;
                    mem_wr_data = {1'b1, old_len_reg, old_start_reg};
                    wr_old_next = 1'b0;
                end
                else if (wr_k_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_idx  = k_idx_reg;
                    mem_wr_data = {1'b0, kw_len_reg, k_start_reg};
                    wr_k_next   = 1'b0;
                end
                else if (wr_app_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_idx  = count_reg[IW-1:0];
                    mem_wr_data = {app_free_reg, app_len_reg, app_start_reg};
                    wr_app_next = 1'b0;
                    count_next  = count_reg + CNTW'(1);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // hold the result until the output register frees
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = res_addr_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= ffba_pkg::HEAP_BASE_RESET;
            hsize_reg     <= ffba_pkg::HEAP_SIZE_RESET;
            used_reg      <= '0;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            chk_v_reg     <= 1'b0;
            old_found_reg <= 1'b0;
            hit_reg       <= 1'b0;
            wr_old_reg    <= 1'b0;
            wr_k_reg      <= 1'b0;
            wr_app_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            hsize_reg     <= hsize_next;
            used_reg      <= used_next;
            count_reg     <= count_next;
            rd_ptr_reg    <= rd_ptr_next;
            chk_v_reg     <= chk_v_next;
            old_found_reg <= old_found_next;
            hit_reg       <= hit_next;
            wr_old_reg    <= wr_old_next;
            wr_k_reg      <= wr_k_next;
            wr_app_reg    <= wr_app_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        addr_reg       <= addr_next;
        size_reg       <= size_next;
        chk_idx_reg    <= chk_idx_next;
        old_idx_reg    <= old_idx_next;
        old_start_reg  <= old_start_next;
        old_len_reg    <= old_len_next;
        k_idx_reg      <= k_idx_next;
        k_start_reg    <= k_start_next;
        k_len_reg      <= k_len_next;
        kw_len_reg     <= kw_len_next;
        app_start_reg  <= app_start_next;
        app_len_reg    <= app_len_next;
        app_free_reg   <= app_free_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

endmodule

FILE: sv/ffba_desc_mem.sv
// Descriptor memory: one write port, one read port, registered read data.
// Stand-alone; holds one packed descriptor {free, length, start} per entry.
module ffba_desc_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 65
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_idx,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_idx,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: tb/sv/ffba_grant_checker.sv
// Grant checker for the first-fit block allocator: mirrors the descriptor list,
// heap top and heap registers, predicts each grant and compares it with m_axis.
// Depends on ffba_pkg.
module ffba_grant_checker #(
    parameter int ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] block_address, [63:32] request_size
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // [31:0] result_address, [33:32] status, zero pad
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [31:0] wr_data,
    output int          pending,
    output int          fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [32:0] ALIGN_MASK = 33'd7;

    typedef struct packed {
        logic [31:0]       addr;
        ffba_pkg::status_t status;
    } grant_t;

    logic [31:0] desc_start  [ENTRIES];
    logic [31:0] desc_length [ENTRIES];
    bit          desc_free   [ENTRIES];
    int          desc_count = 0;
    logic [31:0] heap_used;
    logic [31:0] heap_base;
    logic [31:0] heap_size;
    grant_t      expected_grants [$];
    int          mismatches = 0;

    function automatic int first_fit(int from, logic [31:0] req_size);
        for (int i = from; i < desc_count; i++)
            if (desc_free[i] && desc_length[i] >= req_size)
                return i;
        return -1;
    endfunction

    function automatic int find_block(logic [31:0] where);
        for (int i = 0; i < desc_count; i++)
            if (desc_start[i] == where)
                return i;
        return -1;
    endfunction

    function automatic void add_desc(logic [31:0] start, logic [31:0] len, bit is_free);
        if (desc_count >= ENTRIES)
            return;
        desc_start[desc_count]  = start;
        desc_length[desc_count] = len;
        desc_free[desc_count]   = is_free;
        desc_count++;
    endfunction

    // Shrink descriptor k to the request; split off the rest only if a slot is left
    function automatic logic [31:0] take_fit(int k, logic [31:0] req_size);
        logic [31:0] rest;
        rest = desc_length[k] - req_size;
        desc_free[k] = 1'b0;
        if (rest != 0 && desc_count < ENTRIES)
        begin
            desc_length[k] = req_size;
            add_desc(desc_start[k] + req_size, rest, 1'b1);
        end
        return desc_start[k];
    endfunction

    function automatic ffba_pkg::status_t carve_top(logic [31:0] req_size,
                                                    output logic [31:0] where);
        logic [32:0] rounded;
        rounded = ({1'b0, req_size} + ALIGN_MASK) & ~ALIGN_MASK;
        where = '0;
        if (desc_count >= ENTRIES)
            return ffba_pkg::STATUS_FULL;
        if (64'(heap_used) + 64'(rounded) > 64'(heap_size))
            return ffba_pkg::STATUS_EXHAUSTED;
        where = heap_base + heap_used;
        add_desc(where, rounded[31:0], 1'b0);
        heap_used = heap_used + rounded[31:0];
        return ffba_pkg::STATUS_OK;
    endfunction

    function automatic grant_t serve_request(ffba_pkg::cmd_t op, logic [31:0] where,
                                             logic [31:0] req_size);
        grant_t      g;
        int          k;
        int          old;
        logic [31:0] carved;
        g.addr   = '0;
        g.status = ffba_pkg::STATUS_NOT_FOUND;
        case (op)
            ffba_pkg::CMD_ALLOC:
            begin
                k = first_fit(0, req_size);
                if (k >= 0)
                begin
                    g.addr   = take_fit(k, req_size);
                    g.status = ffba_pkg::STATUS_OK;
                end
                else
                begin
                    g.status = carve_top(req_size, carved);
                    g.addr   = carved;
                end
            end
            ffba_pkg::CMD_FREE:
            begin
                k = find_block(where);
                if (k >= 0)
                begin
                    desc_free[k] = 1'b1;
                    g.status     = ffba_pkg::STATUS_OK;
                end
            end
            ffba_pkg::CMD_REALLOC:
            begin
                old = find_block(where);
                if (old >= 0)
                begin
                    k = first_fit(old, req_size);
                    if (k >= 0)
                    begin
                        // release before take_fit, so the block ends up used when k is the old block
                        desc_free[old] = 1'b1;
                        g.addr         = take_fit(k, req_size);
                        g.status       = ffba_pkg::STATUS_OK;
                    end
                    else
                    begin
                        g.status = carve_top(req_size, carved);
                        g.addr   = carved;
                        if (g.status == ffba_pkg::STATUS_OK)
                            desc_free[old] = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (g.status != ffba_pkg::STATUS_OK || op == ffba_pkg::CMD_FREE)
            g.addr = '0;
        return g;
    endfunction

    always @(posedge clk)
    begin
        grant_t want;
        grant_t got;
        if (!rst_n)
        begin
            expected_grants.delete();
            desc_count = 0;
            heap_used  = '0;
            heap_base  = ffba_pkg::HEAP_BASE_RESET;
            heap_size  = ffba_pkg::HEAP_SIZE_RESET;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.addr   = m_axis_tdata[31:0];
                got.status = m_axis_tdata[33:32];
                if (expected_grants.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, addr %h status %0d",
                             $time, got.addr, got.status);
                    mismatches++;
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (got.addr !== want.addr)
                    begin
                        $display("%0t: result_address expected %h actual %h",
                                 $time, want.addr, got.addr);
                        mismatches++;
                    end
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        mismatches++;
                    end
                end
            end
            if (wr_en)
            begin
                if (wr_index == ffba_pkg::REG_HEAP_BASE)
                    heap_base = wr_data;
                else
                    heap_size = wr_data;
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_grants.push_back(serve_request(s_axis_tuser, s_axis_tdata[31:0],
                                                        s_axis_tdata[63:32]));
        end
        pending    <= expected_grants.size();
        fail_count <= mismatches;
    end

endmodule

FILE: tb/sv/tb.sv
// Top of the first-fit block allocator testbench: clock, reset, request and
// heap register stimulus, output stalls and the verdict.
// Depends on ffba_pkg, first_fit_block_allocator and ffba_grant_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam ffba_pkg::cmd_t CMD_SPARE = 2'd3;
    localparam int   LIMIT_CYCLES    = 1_000_000;
    localparam int   ITEMS_PER_PHASE = 488;
    localparam int   DRAIN_CYCLES    = 100;
    localparam int   POOL_DEPTH      = 64;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // [31:0] block_address, [63:32] request_size
    logic [1:0]  s_axis_tuser;   // [1:0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [31:0] result_address, [33:32] status, zero pad
    logic        wr_en;
    logic        wr_index;
    logic [31:0] wr_data;

    int          pending;
    int          fail_count;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic [31:0] addr_pool [POOL_DEPTH];
    int          pool_fill = 0;
    int          pool_wr = 0;

    first_fit_block_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data)
    );

    ffba_grant_checker grant_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Keep recently granted addresses so frees and reallocs mostly hit live blocks
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready && m_axis_tdata[33:32] == ffba_pkg::STATUS_OK
            && m_axis_tdata[31:0] != '0)
        begin
            addr_pool[pool_wr] <= m_axis_tdata[31:0];
            pool_wr <= (pool_wr + 1) % POOL_DEPTH;
            if (pool_fill < POOL_DEPTH)
                pool_fill <= pool_fill + 1;
        end
    end

    task automatic send_request(ffba_pkg::cmd_t op, logic [31:0] where,
                                logic [31:0] req_size);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {req_size, where};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic send_random();
        int             pick;
        ffba_pkg::cmd_t op;
        logic [31:0]    where;
        logic [31:0]    req_size;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            op = ffba_pkg::CMD_ALLOC;
        else if (pick < 70)
            op = ffba_pkg::CMD_FREE;
        else if (pick < 95)
            op = ffba_pkg::CMD_REALLOC;
        else
            op = CMD_SPARE;
        if (pool_fill != 0 && $urandom_range(0, 9) < 8)
            where = addr_pool[$urandom_range(0, pool_fill - 1)];
        else
            where = $urandom;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            req_size = $urandom_range(0, 128);
        else if (pick < 9)
            req_size = $urandom_range(0, 4096);
        else
            req_size = $urandom;
        send_request(op, where, req_size);
    endtask

    // Drop valid and hold until every granted result has been taken
    task automatic wait_all_granted();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic set_heap(logic [31:0] base, logic [31:0] limit);
        wr_en    <= 1'b1;
        wr_index <= ffba_pkg::REG_HEAP_BASE;
        wr_data  <= base;
        @(posedge clk);
        wr_index <= ffba_pkg::REG_HEAP_SIZE;
        wr_data  <= limit;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int phase;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ffba_pkg::CMD_ALLOC;
        wr_en         <= 1'b0;
        wr_index      <= ffba_pkg::REG_HEAP_BASE;
        wr_data       <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list under the reset heap registers
        send_request(CMD_SPARE, $urandom, $urandom);
        send_request(ffba_pkg::CMD_FREE, 32'h0, 32'h0);
        send_request(ffba_pkg::CMD_REALLOC, 32'd4096, 32'd8);
        send_request(ffba_pkg::CMD_ALLOC, 32'h0, 32'h0);
        send_request(ffba_pkg::CMD_ALLOC, 32'h0, 32'd100);
        send_request(ffba_pkg::CMD_ALLOC, 32'h0, 32'hFFFF_FFFF);
        send_request(ffba_pkg::CMD_ALLOC, 32'h0, 32'd65536);
        wait_all_granted();

        // Heap top wraps past the address space; limit tight enough to exhaust
        set_heap(32'hFFFF_FFF8, 32'd200);
        send_request(ffba_pkg::CMD_ALLOC, 32'h0, 32'd96);
        send_request(ffba_pkg::CMD_ALLOC, 32'h0, 32'd1);
        send_request(ffba_pkg::CMD_FREE, 32'd4096, 32'h0);
        send_request(ffba_pkg::CMD_FREE, 32'd4096, 32'h0);
        send_request(ffba_pkg::CMD_REALLOC, 32'd4096, 32'd50);
        send_request(ffba_pkg::CMD_FREE, 32'h60, 32'h0);
        send_request(ffba_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 32'd40);
        send_request(ffba_pkg::CMD_REALLOC, 32'h88, 32'd56);
        send_request(ffba_pkg::CMD_ALLOC, 32'h0, 32'h0);
        send_request(ffba_pkg::CMD_REALLOC, 32'h60, 32'd10);
        send_request(ffba_pkg::CMD_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(ffba_pkg::CMD_FREE, 32'hDEAD_BEEF, 32'h0);
        send_request(CMD_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_all_granted();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    set_heap(32'h0, 32'hFFFF_FFFF);
                end
                1:
                begin
                    send_idle_pct = 66;
                    stall_pct     = 0;
                    set_heap(32'hFFFF_FFFF, 32'h0);
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 66;
                    set_heap($urandom, $urandom_range(0, 32'h0010_0000));
                end
                default:
                begin
                    send_idle_pct = 21;
                    stall_pct     = 21;
                    set_heap($urandom, $urandom);
                end
            endcase
            repeat (ITEMS_PER_PHASE) send_random();
            wait_all_granted();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
